FILE: hdl/gmd_pkg.sv
// Package for the gzip member deframer: phase and status codes, the item passed
// from the header parser to the tail stage, and the header CRC-32 byte update.
// No dependencies.
`default_nettype none

package gmd_pkg;

  localparam int unsigned LengthBitsDefault = 32;
  localparam int unsigned FifoDepthDefault  = 4;

  localparam logic [7:0]  MAGIC_ID1       = 8'h1F;
  localparam logic [7:0]  MAGIC_ID2       = 8'h8B;
  localparam logic [7:0]  METHOD_DEFLATE  = 8'd8;
  localparam logic [7:0]  FLG_RESERVED    = 8'hE0;
  localparam logic [31:0] CRC_INIT        = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY        = 32'hEDB8_8320;
  localparam logic [31:0] MAX_SIZE_RESET  = 32'd100000000;
  localparam int unsigned MIN_MEMBER_LEN  = 18;
  localparam int unsigned TAIL_BYTES      = 8;
  localparam int unsigned FIXED_HDR_LAST  = 9;

  localparam int unsigned FLG_HCRC_BIT    = 1;
  localparam int unsigned FLG_EXTRA_BIT   = 2;
  localparam int unsigned FLG_NAME_BIT    = 3;
  localparam int unsigned FLG_COMMENT_BIT = 4;

  typedef enum logic [2:0] {
    PH_FIXED   = 3'd0,
    PH_XLEN    = 3'd1,
    PH_XSKIP   = 3'd2,
    PH_NAME    = 3'd3,
    PH_COMMENT = 3'd4,
    PH_HCRC    = 3'd5,
    PH_BODY    = 3'd6,
    PH_ERROR   = 3'd7
  } gmd_phase_e;

  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_MAGIC     = 4'd1,
    ST_METHOD    = 4'd2,
    ST_RESERVED  = 4'd3,
    ST_TRUNCATED = 4'd4,
    ST_HDR_CRC   = 4'd5,
    ST_SIZE      = 4'd6,
    ST_EMPTY     = 4'd7,
    ST_SHORT     = 4'd8
  } gmd_status_e;

  // One classified byte from the header parser to the tail stage.
  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic        is_body;
    gmd_status_e pre_status;   // final status when nonzero, else decided by the tail
  } gmd_item_t;

  function automatic logic [31:0] crc_byte(logic [31:0] c, logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

  // Next optional header field after ph, per the FLG byte.
  function automatic gmd_phase_e next_after(gmd_phase_e ph, logic [7:0] flags);
    gmd_phase_e n;
    if (ph < PH_XLEN && flags[FLG_EXTRA_BIT]) n = PH_XLEN;
    else if (ph < PH_NAME && flags[FLG_NAME_BIT]) n = PH_NAME;
    else if (ph < PH_COMMENT && flags[FLG_COMMENT_BIT]) n = PH_COMMENT;
    else if (ph < PH_HCRC && flags[FLG_HCRC_BIT]) n = PH_HCRC;
    else n = PH_BODY;
    return n;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/gmd_front.sv
// Header parser: accepts member bytes, walks the gzip header fields, checks
// magic, method, flags and header CRC, and classifies each byte. Uses gmd_pkg.
`default_nettype none

module gmd_front import gmd_pkg::*; #(
  parameter int unsigned LENGTH_BITS = LengthBitsDefault
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      accept_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic      last_byte_i,
  output gmd_item_t      item_o
);

  gmd_phase_e              phase_q, phase_d, phase_nx;
  logic [7:0]              flags_q, flags_d;
  logic [15:0]             count_q, count_d;
  logic [31:0]             crc_q, crc_d;
  logic [7:0]              hcrc_lo_q, hcrc_lo_d;
  logic                    half_q, half_d;
  logic [LENGTH_BITS-1:0]  len_q, len_d, len_nx;
  gmd_status_e             err_q, err_d, err_nx;
  logic [31:0]             crc_upd;
  logic [15:0]             cnt_full, cnt_m1;

  assign crc_upd  = crc_byte(crc_q, data_byte_i);
  assign cnt_full = {data_byte_i, count_q[7:0]};
  assign cnt_m1   = count_q - 16'd1;
  assign len_nx   = (len_q == '1) ? len_q : len_q + LENGTH_BITS'(1);

  // Next state
  always_comb begin
    phase_nx  = phase_q;
    flags_d   = flags_q;
    count_d   = count_q;
    crc_d     = crc_q;
    hcrc_lo_d = hcrc_lo_q;
    half_d    = half_q;
    err_nx    = err_q;
    unique case (phase_q)
      PH_FIXED: begin
        crc_d   = crc_upd;
        count_d = count_q + 16'd1;
        if ((count_q == 16'd0 && data_byte_i != MAGIC_ID1) ||
            (count_q == 16'd1 && data_byte_i != MAGIC_ID2)) begin
          err_nx = ST_MAGIC; phase_nx = PH_ERROR;
        end else if (count_q == 16'd2 && data_byte_i != METHOD_DEFLATE) begin
          err_nx = ST_METHOD; phase_nx = PH_ERROR;
        end else if (count_q == 16'd3 && (data_byte_i & FLG_RESERVED) != 8'd0) begin
          err_nx = ST_RESERVED; phase_nx = PH_ERROR;
        end else begin
          if (count_q == 16'd3) flags_d = data_byte_i;
          if (count_q >= 16'(FIXED_HDR_LAST)) begin
            count_d  = 16'd0;
            phase_nx = next_after(PH_FIXED, flags_q);
          end
        end
      end
      PH_XLEN: begin
        crc_d = crc_upd;
        if (!half_q) begin
          count_d = {8'd0, data_byte_i};
          half_d  = 1'b1;
        end else begin
          count_d  = cnt_full;
          half_d   = 1'b0;
          phase_nx = (cnt_full != 16'd0) ? PH_XSKIP : next_after(PH_XSKIP, flags_q);
        end
      end
      PH_XSKIP: begin
        crc_d   = crc_upd;
        count_d = cnt_m1;
        if (cnt_m1 == 16'd0) phase_nx = next_after(PH_XSKIP, flags_q);
      end
      PH_NAME, PH_COMMENT: begin
        crc_d = crc_upd;
        if (data_byte_i == 8'd0) phase_nx = next_after(phase_q, flags_q);
      end
      PH_HCRC: begin
        if (!half_q) begin
          hcrc_lo_d = data_byte_i;
          half_d    = 1'b1;
        end else begin
          half_d = 1'b0;
          if ({data_byte_i, hcrc_lo_q} != ~crc_q[15:0]) begin
            err_nx = ST_HDR_CRC; phase_nx = PH_ERROR;
          end else begin
            phase_nx = PH_BODY;
          end
        end
      end
      PH_BODY, PH_ERROR: ;
      default: ;
    endcase

    phase_d = phase_nx;
    err_d   = err_nx;
    len_d   = len_nx;
    // Clear the member state on its last byte
    if (last_byte_i) begin
      phase_d   = PH_FIXED;
      flags_d   = 8'd0;
      count_d   = 16'd0;
      crc_d     = CRC_INIT;
      hcrc_lo_d = 8'd0;
      half_d    = 1'b0;
      err_d     = ST_OK;
      len_d     = '0;
    end
  end

  // Outputs
  always_comb begin
    item_o.data       = data_byte_i;
    item_o.last       = last_byte_i;
    item_o.is_body    = (phase_q == PH_BODY);
    item_o.pre_status = ST_OK;
    if (last_byte_i) begin
      priority if (len_nx < LENGTH_BITS'(MIN_MEMBER_LEN)) item_o.pre_status = ST_SHORT;
      else if (err_nx != ST_OK)                           item_o.pre_status = err_nx;
      else if (phase_nx != PH_BODY)                       item_o.pre_status = ST_TRUNCATED;
      else                                                item_o.pre_status = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_FIXED;
      flags_q   <= 8'd0;
      count_q   <= 16'd0;
      crc_q     <= CRC_INIT;
      hcrc_lo_q <= 8'd0;
      half_q    <= 1'b0;
      err_q     <= ST_OK;
      len_q     <= '0;
    end else if (accept_i) begin
      phase_q   <= phase_d;
      flags_q   <= flags_d;
      count_q   <= count_d;
      crc_q     <= crc_d;
      hcrc_lo_q <= hcrc_lo_d;
      half_q    <= half_d;
      err_q     <= err_d;
      len_q     <= len_d;
    end
  end

  a_error_latched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_ERROR) |-> (err_q != ST_OK))
    else $error("error phase without a latched code");

  a_fixed_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_FIXED && err_q == ST_OK) |-> (count_q <= 16'(FIXED_HDR_LAST)))
    else $error("fixed header index out of range");

endmodule

`default_nettype wire

FILE: hdl/gmd_fifo.sv
// Short queue of classified items between the header parser and the tail
// stage. Uses gmd_pkg for the item type.
`default_nettype none

module gmd_fifo import gmd_pkg::*; #(
  parameter int unsigned DEPTH = FifoDepthDefault
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      wr_en_i,
  input  wire gmd_item_t wr_item_i,
  output logic           full_o,
  output logic           valid_o,
  input  wire logic      rd_en_i,
  output gmd_item_t      rd_item_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  gmd_item_t       mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_wr, do_rd;

  assign full_o    = (count_q == CntW'(DEPTH));
  assign valid_o   = (count_q != '0);
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && valid_o;
  assign rd_item_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wr_ptr_q] <= wr_item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      if (do_rd) rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      if (do_wr && !do_rd)      count_q <= count_q + CntW'(1);
      else if (do_rd && !do_wr) count_q <= count_q - CntW'(1);
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("queue count beyond depth");

endmodule

`default_nettype wire

FILE: hdl/gmd_back.sv
// Tail stage: runs the 8-byte delay line, releases body bytes, extracts the
// footer and settles the member status. Holds the size limit register. Uses gmd_pkg.
`default_nettype none

module gmd_back import gmd_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  input  wire logic        item_valid_i,
  input  wire gmd_item_t   item_i,
  output logic             item_take_o,
  output logic             out_valid_o,
  input  wire logic        out_pop_i,
  output logic [7:0]       payload_byte_o,
  output logic             payload_valid_o,
  output logic             payload_last_o,
  output logic             member_done_o,
  output logic [3:0]       status_o,
  output logic [31:0]      footer_crc_o,
  output logic [31:0]      footer_size_o
);

  logic [31:0] max_q;
  logic [7:0]  delay_q [TAIL_BYTES];
  logic [7:0]  delay_d [TAIL_BYTES];
  logic [3:0]  fill_q, fill_d, fill_nx;
  logic        seen_q, seen_d, seen_nx;
  logic        out_valid_q;
  logic [7:0]  pay_q, pay_d;
  logic        pay_valid_q, pay_valid_d;
  logic        last_q;
  gmd_status_e status_q, status_d;
  logic [31:0] fcrc_q, fcrc_d, fsize_q, fsize_d, fsize_nx;
  logic        have_footer;

  assign item_take_o = item_valid_i && (!out_valid_q || out_pop_i);

  always_comb begin
    delay_d     = delay_q;
    fill_nx     = fill_q;
    seen_nx     = seen_q;
    pay_d       = 8'd0;
    pay_valid_d = 1'b0;
    if (item_i.is_body) begin
      if (fill_q == 4'(TAIL_BYTES)) begin
        // Shift the delay line and release its oldest byte
        pay_d       = delay_q[0];
        pay_valid_d = 1'b1;
        seen_nx     = 1'b1;
        for (int i = 0; i < TAIL_BYTES - 1; i++) delay_d[i] = delay_q[i+1];
        delay_d[TAIL_BYTES-1] = item_i.data;
      end else begin
        delay_d[fill_q[2:0]] = item_i.data;
        fill_nx              = fill_q + 4'd1;
      end
    end

    have_footer = item_i.last && (fill_nx == 4'(TAIL_BYTES));
    fsize_nx    = {delay_d[7], delay_d[6], delay_d[5], delay_d[4]};
    fcrc_d      = have_footer ? {delay_d[3], delay_d[2], delay_d[1], delay_d[0]} : 32'd0;
    fsize_d     = have_footer ? fsize_nx : 32'd0;

    status_d = ST_OK;
    if (item_i.last) begin
      priority if (item_i.pre_status != ST_OK)        status_d = item_i.pre_status;
      else if (have_footer && fsize_nx > max_q)       status_d = ST_SIZE;
      else if (!seen_nx)                              status_d = ST_EMPTY;
      else                                            status_d = ST_OK;
    end

    fill_d = item_i.last ? 4'd0 : fill_nx;
    seen_d = item_i.last ? 1'b0 : seen_nx;
  end

  always_ff @(posedge clk_i) begin
    if (item_take_o) begin
      delay_q     <= delay_d;
      pay_q       <= pay_d;
      pay_valid_q <= pay_valid_d;
      last_q      <= item_i.last;
      status_q    <= status_d;
      fcrc_q      <= fcrc_d;
      fsize_q     <= fsize_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q       <= MAX_SIZE_RESET;
      fill_q      <= 4'd0;
      seen_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) max_q <= cfg_wdata_i;
      if (item_take_o) begin
        fill_q <= fill_d;
        seen_q <= seen_d;
      end
      // Hold the result until popped; refill in the same cycle
      if (item_take_o)    out_valid_q <= 1'b1;
      else if (out_pop_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign payload_byte_o  = pay_q;
  assign payload_valid_o = pay_valid_q;
  assign payload_last_o  = pay_valid_q && last_q;
  assign member_done_o   = last_q;
  assign status_o        = status_q;
  assign footer_crc_o    = fcrc_q;
  assign footer_size_o   = fsize_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= 4'(TAIL_BYTES))
    else $error("delay line fill beyond its length");

  a_status_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !last_q) |-> (status_q == ST_OK && fcrc_q == 32'd0))
    else $error("status or footer reported mid-member");

endmodule

`default_nettype wire

FILE: hdl/gzip_member_deframer.sv
// Top level of the gzip member deframer: header parser, item queue and tail
// stage. Uses gmd_pkg, gmd_front, gmd_fifo and gmd_back.
//
//   channel   ports                                   transaction when
//   input     push, full, data_byte_i, last_byte_i    push && !full
//   result    empty, pop, payload_*, member_done_o,   pop && !empty
//             status_o, footer_crc_o, footer_size_o
//   config    cfg_we_i, cfg_wdata_i                   cfg_we_i
//
// One byte in and one result out per cycle sustained while pop keeps up; the
// header parser settles a byte (fixed header, optional fields, CRC-32 byte
// update) in the cycle it is accepted. A result passes through the item queue
// and the output register before it reaches the result ports. Reset leaves
// the block ready at once with no clearing pass.
// A stalled result side fills the output register, then the item queue
// (FIFO_DEPTH entries), and only then raises full.
`default_nettype none

module gzip_member_deframer import gmd_pkg::*; #(
  parameter int unsigned LENGTH_BITS = LengthBitsDefault,
  parameter int unsigned FIFO_DEPTH  = FifoDepthDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        last_byte_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       payload_byte_o,
  output logic             payload_valid_o,
  output logic             payload_last_o,
  output logic             member_done_o,
  output logic [3:0]       status_o,
  output logic [31:0]      footer_crc_o,
  output logic [31:0]      footer_size_o,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i
);

  gmd_item_t front_item, queue_item;
  logic      accept, queue_full, queue_valid, queue_take, out_valid;

  assign accept = push && !queue_full;
  assign full   = queue_full;
  assign empty  = !out_valid;

  gmd_front #(.LENGTH_BITS(LENGTH_BITS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .item_o      (front_item)
  );

  gmd_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (accept),
    .wr_item_i (front_item),
    .full_o    (queue_full),
    .valid_o   (queue_valid),
    .rd_en_i   (queue_take),
    .rd_item_o (queue_item)
  );

  gmd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .item_valid_i    (queue_valid),
    .item_i          (queue_item),
    .item_take_o     (queue_take),
    .out_valid_o     (out_valid),
    .out_pop_i       (pop),
    .payload_byte_o  (payload_byte_o),
    .payload_valid_o (payload_valid_o),
    .payload_last_o  (payload_last_o),
    .member_done_o   (member_done_o),
    .status_o        (status_o),
    .footer_crc_o    (footer_crc_o),
    .footer_size_o   (footer_size_o)
  );

endmodule

`default_nettype wire
